@@ sv/plchs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plchs_pkg
// types, constants and the geometry table for the partition lba to chs encoder
// ----------------------------------------------------------------------------
package plchs_pkg;

    localparam logic [31:0] CHS_LBA_LIMIT = 32'h00FB_0400;
    localparam int          PIPE_DEPTH    = 5;
    localparam int          GEOM_ENTRIES  = 10;

    // floor(2^24 / 63) and floor(2^28 / 255)
    localparam logic [18:0] SPT63_RECIP   = 19'h41041;
    localparam logic [20:0] HEADS255_RECIP = 21'h101010;

    typedef enum logic [1:0] {
        SPT_16,
        SPT_32,
        SPT_63
    } spt_sel_t;

    // heads is 1 << heads_log, or 255 when heads_255 is set
    typedef struct packed {
        spt_sel_t   spt_sel;
        logic [2:0] heads_log;
        logic       heads_255;
    } geom_t;

    typedef struct packed {
        logic [31:0] start_lba;
        logic [31:0] sector_count;
    } cmd_t;

    typedef struct packed {
        logic [7:0] start_head;
        logic [7:0] start_cyl_low;
        logic [7:0] start_sec_byte;
        logic [7:0] end_head;
        logic [7:0] end_cyl_low;
        logic [7:0] end_sec_byte;
    } result_t;

    // quotient and remainder by sectors per track
    typedef struct packed {
        logic        over;
        logic [19:0] trk;
        logic [5:0]  sec_idx;
        geom_t       geom;
    } trk_t;

    typedef struct packed {
        logic [7:0] head;
        logic [7:0] cyl_low;
        logic [7:0] sec_byte;
    } chs_t;

    localparam logic [31:0] GEOM_MAX [GEOM_ENTRIES-1] = '{
        32'h0000_1000, 32'h0000_8000, 32'h0001_0000, 32'h0004_0000, 32'h0008_0000,
        32'h000F_C000, 32'h001F_8000, 32'h003F_0000, 32'h007E_0000
    };

    localparam geom_t GEOM_TBL [GEOM_ENTRIES] = '{
        '{spt_sel: SPT_16, heads_log: 3'd1, heads_255: 1'b0},
        '{spt_sel: SPT_32, heads_log: 3'd1, heads_255: 1'b0},
        '{spt_sel: SPT_32, heads_log: 3'd2, heads_255: 1'b0},
        '{spt_sel: SPT_32, heads_log: 3'd3, heads_255: 1'b0},
        '{spt_sel: SPT_32, heads_log: 3'd4, heads_255: 1'b0},
        '{spt_sel: SPT_63, heads_log: 3'd4, heads_255: 1'b0},
        '{spt_sel: SPT_63, heads_log: 3'd5, heads_255: 1'b0},
        '{spt_sel: SPT_63, heads_log: 3'd6, heads_255: 1'b0},
        '{spt_sel: SPT_63, heads_log: 3'd7, heads_255: 1'b0},
        '{spt_sel: SPT_63, heads_log: 3'd0, heads_255: 1'b1}
    };

    // first entry whose maximum is at least the drive size
    function automatic geom_t geom_pick(input logic [31:0] size);
        geom_t g;
        g = GEOM_TBL[GEOM_ENTRIES-1];
        for (int i = GEOM_ENTRIES - 2; i >= 0; i--) begin
            if (size <= GEOM_MAX[i])
            begin
                g = GEOM_TBL[i];
            end
        end
        return g;
    endfunction

endpackage
`default_nettype wire

@@ sv/plchs_div_spt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plchs_div_spt
// two stage split of an lba into track number and sector index
// ----------------------------------------------------------------------------
module plchs_div_spt
    import plchs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic [31:0] lba,
    input  wire geom_t       geom,
    output trk_t             trk
);

    logic [23:0] x_reg;
    logic        over_reg;
    logic [42:0] prod_reg;
    geom_t       geom_reg;
    trk_t        trk_reg;
    trk_t        trk_next;

    logic [18:0] q_est;
    logic [25:0] mul63;
    logic [25:0] diff;
    logic [6:0]  rem7;
    logic [19:0] q63;
    logic [5:0]  r63;

    always_ff @(posedge clk)
    begin
        x_reg    <= lba[23:0];
        over_reg <= (lba >= CHS_LBA_LIMIT);
        prod_reg <= 43'(lba[23:0]) * 43'(SPT63_RECIP);
        geom_reg <= geom;
        trk_reg  <= trk_next;
    end

    // reciprocal estimate is low by at most one
    always_comb
    begin
        q_est = prod_reg[42:24];
        mul63 = {1'b0, q_est, 6'b0} - 26'(q_est);
        diff  = {2'b0, x_reg} - mul63;
        rem7  = diff[6:0];
        if (rem7 >= 7'd63)
        begin
            q63 = 20'(q_est) + 20'd1;
            r63 = 6'(rem7 - 7'd63);
        end
        else
        begin
            q63 = 20'(q_est);
            r63 = rem7[5:0];
        end

        trk_next.over = over_reg;
        trk_next.geom = geom_reg;
        unique case (geom_reg.spt_sel)
            SPT_16:
            begin
                trk_next.trk     = x_reg[23:4];
                trk_next.sec_idx = {2'b0, x_reg[3:0]};
            end
            SPT_32:
            begin
                trk_next.trk     = {1'b0, x_reg[23:5]};
                trk_next.sec_idx = {1'b0, x_reg[4:0]};
            end
            default:
            begin
                trk_next.trk     = q63;
                trk_next.sec_idx = r63;
            end
        endcase
    end

    assign trk = trk_reg;

endmodule
`default_nettype wire

@@ sv/plchs_div_heads.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// plchs_div_heads
// two stage split of a track number into cylinder and head, chs byte packing
// ----------------------------------------------------------------------------
module plchs_div_heads
    import plchs_pkg::*;
(
    input  wire logic clk,
    input  wire trk_t trk,
    output chs_t      chs
);

    trk_t        trk_reg;
    logic [40:0] prod_reg;
    chs_t        chs_reg;
    chs_t        chs_next;

    logic [12:0] cyl_est;
    logic [20:0] mul255;
    logic [20:0] diff;
    logic [8:0]  rem9;
    logic [19:0] cyl;
    logic [7:0]  head;
    logic [19:0] head_mask;
    logic [5:0]  sec_num;

    always_ff @(posedge clk)
    begin
        trk_reg  <= trk;
        prod_reg <= 41'(trk.trk) * 41'(HEADS255_RECIP);
        chs_reg  <= chs_next;
    end

    always_comb
    begin
        cyl_est   = prod_reg[40:28];
        mul255    = {cyl_est, 8'b0} - 21'(cyl_est);
        diff      = {1'b0, trk_reg.trk} - mul255;
        rem9      = diff[8:0];
        head_mask = ~(20'hF_FFFF << trk_reg.geom.heads_log);

        if (trk_reg.geom.heads_255)
        begin
            // estimate is low by at most one
            if (rem9 >= 9'd255)
            begin
                cyl  = 20'(cyl_est) + 20'd1;
                head = 8'(rem9 - 9'd255);
            end
            else
            begin
                cyl  = 20'(cyl_est);
                head = rem9[7:0];
            end
        end
        else
        begin
            cyl  = trk_reg.trk >> trk_reg.geom.heads_log;
            head = 8'(trk_reg.trk & head_mask);
        end

        sec_num = trk_reg.sec_idx + 6'd1;

        if (trk_reg.over)
        begin
            chs_next = '{head: 8'hFF, cyl_low: 8'hFF, sec_byte: 8'hFF};
        end
        else
        begin
            chs_next.head     = head;
            chs_next.cyl_low  = cyl[7:0];
            chs_next.sec_byte = {cyl[9:8], sec_num};
        end
    end

    assign chs = chs_reg;

endmodule
`default_nettype wire

@@ sv/partition_lba_to_chs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// partition_lba_to_chs
// encodes the chs triples of a partition's first and last sector
// ----------------------------------------------------------------------------
//  channel   ports                    handshake
//  command   start, busy, cmd         taken when start is high and busy is low
//  result    done, result             one cycle per transaction, no backpressure
//  config    cfg_we, cfg_wdata        drive size written when cfg_we is high
//
// one transaction per cycle while busy is low; the command is registered with
// its last-sector add, then multiplied and corrected by sectors per track,
// then multiplied and corrected by heads, and done is high with the result.
// reset clears the valid pipeline and the drive size; busy is high only
// while in reset and the cycle after, and never stalls the pipeline since the
// receiver cannot hold results off.
// ----------------------------------------------------------------------------
module partition_lba_to_chs
    import plchs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        cmd,
    output logic             done,
    output result_t          result,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    logic [31:0]           drive_size_reg;
    logic                  busy_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;

    logic [31:0] first_lba_reg;
    logic [31:0] last_lba_reg;
    logic [31:0] last_lba_next;
    geom_t       geom_reg;

    logic [32:0] sum;
    trk_t        first_trk;
    trk_t        last_trk;
    chs_t        first_chs;
    chs_t        last_chs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_size_reg <= '0;
            busy_reg       <= 1'b1;
            valid_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                drive_size_reg <= cfg_wdata;
            end
            busy_reg  <= 1'b0;
            valid_reg <= valid_next;
        end
    end

    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], start & ~busy_reg};

    // last sector, zero count counts as one, saturates at all ones
    always_comb
    begin
        if (cmd.sector_count == '0)
        begin
            sum = {1'b0, cmd.start_lba};
        end
        else
        begin
            sum = {1'b0, cmd.start_lba} + {1'b0, cmd.sector_count} - 33'd1;
        end
        last_lba_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        first_lba_reg <= cmd.start_lba;
        last_lba_reg  <= last_lba_next;
        geom_reg      <= geom_pick(drive_size_reg);
    end

    plchs_div_spt u_first_spt (
        .clk  (clk),
        .lba  (first_lba_reg),
        .geom (geom_reg),
        .trk  (first_trk)
    );

    plchs_div_spt u_last_spt (
        .clk  (clk),
        .lba  (last_lba_reg),
        .geom (geom_reg),
        .trk  (last_trk)
    );

    plchs_div_heads u_first_heads (
        .clk (clk),
        .trk (first_trk),
        .chs (first_chs)
    );

    plchs_div_heads u_last_heads (
        .clk (clk),
        .trk (last_trk),
        .chs (last_chs)
    );

    assign busy = busy_reg;
    assign done = valid_reg[PIPE_DEPTH-1];

    always_comb
    begin
        result.start_head     = first_chs.head;
        result.start_cyl_low  = first_chs.cyl_low;
        result.start_sec_byte = first_chs.sec_byte;
        result.end_head       = last_chs.head;
        result.end_cyl_low    = last_chs.cyl_low;
        result.end_sec_byte   = last_chs.sec_byte;
    end

endmodule
`default_nettype wire
